@@ design/bcmq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcmq_pkg
// Types and constants shared by the bucket count min queue and its checker.
// ----------------------------------------------------------------------------
package bcmq_pkg;

	localparam int MODE_W   = 2;
	localparam int VALUE_W  = 4;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 24;

	// bitmap scan width per cycle
	localparam int CHUNK_BITS = 4;
	localparam int CHUNK      = 1 << CHUNK_BITS;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUT   = 2'd0,
		MODE_GET   = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_MARKER = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_SAT    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_CALC,
		S_HOLD
	} state_t;

endpackage

@@ design/bcmq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcmq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bcmq_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/bucket_count_min_queue_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucket_count_min_queue_top
// Min priority queue of small values kept as one saturating counter per
// value, with a bitmap of nonzero counters for the smallest-value search.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   mode, value
//  out      out_valid / out_ready taken_value, status, pending_total
//
//  Put: counter RAM read, then modify-write. Get: scan of 16-bit bitmap
//  chunks, at most ceil(NUM_VALUES/16), then on a hit a counter RAM read
//  and modify-write. Clear, unused mode and an out-of-range put finish
//  when accepted. One item at a time; in_ready is high only when the
//  sequencer is idle. A result waiting in the output register holds the
//  sequencer until it is taken. Reset clears the bitmap and total; RAM
//  entries with a clear bitmap bit read as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module bucket_count_min_queue_top #(
	parameter int NUM_VALUES = 16,
	parameter int COUNT_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bcmq_pkg::MODE_W-1:0]   mode,
	input  logic [bcmq_pkg::VALUE_W-1:0]  value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bcmq_pkg::VALUE_W-1:0]  taken_value,
	output logic [bcmq_pkg::STATUS_W-1:0] status,
	output logic [bcmq_pkg::TOTAL_W-1:0]  pending_total
);

	localparam int IDX_W  = $clog2(NUM_VALUES);
	localparam int NCHUNK = (NUM_VALUES + bcmq_pkg::CHUNK - 1) / bcmq_pkg::CHUNK;
	localparam int CI_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int PAD_W  = NCHUNK * bcmq_pkg::CHUNK;

	bcmq_pkg::state_t  state_q, state_d;
	bcmq_pkg::mode_t   op_q;
	bcmq_pkg::status_t fin_status, res_status_q;

	logic [NUM_VALUES-1:0]           nz_q;
	logic [bcmq_pkg::TOTAL_W-1:0]    total_q, total_d;
	logic [IDX_W-1:0]                idx_q;
	logic [CI_W-1:0]                 chunk_q;
	logic [bcmq_pkg::VALUE_W-1:0]    fin_taken, res_taken_q;
	logic                            fin_valid;
	logic                            accept, out_free, in_range;
	logic                            nz_set, nz_clr, nz_clr_all;

	logic [PAD_W-1:0]                nz_pad;
	logic [bcmq_pkg::CHUNK-1:0]      chunk_bits;
	logic [bcmq_pkg::CHUNK_BITS-1:0] enc;
	logic                            found, last_chunk;
	logic [IDX_W-1:0]                scan_idx;

	logic                            ram_we, ram_re;
	logic [IDX_W-1:0]                ram_raddr;
	logic [COUNT_BITS-1:0]           ram_wdata, ram_rdata, cnt;

	assign in_ready = (state_q == bcmq_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;
	assign in_range = (32'(value) < 32'(NUM_VALUES));

	// bucket 0 is the end marker and never wins the scan
	assign nz_pad     = {(PAD_W - 1)'(nz_q[NUM_VALUES-1:1]), 1'b0};
	assign chunk_bits = nz_pad[chunk_q * bcmq_pkg::CHUNK +: bcmq_pkg::CHUNK];
	assign found      = |chunk_bits;
	assign last_chunk = (chunk_q == CI_W'(NCHUNK - 1));
	assign scan_idx   = IDX_W'({chunk_q, enc});

	always_comb begin
		enc = '0;
		for (int i = bcmq_pkg::CHUNK - 1; i >= 0; i--) begin
			if (chunk_bits[i]) begin
				enc = bcmq_pkg::CHUNK_BITS'(i);
			end
		end
	end

	// entries whose bitmap bit is clear are stale and count as zero
	assign cnt = nz_q[idx_q] ? ram_rdata : '0;

	bcmq_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(NUM_VALUES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d    = state_q;
		ram_re     = 1'b0;
		ram_raddr  = IDX_W'(value);
		ram_we     = 1'b0;
		ram_wdata  = cnt + COUNT_BITS'(1);
		fin_valid  = 1'b0;
		fin_taken  = '0;
		fin_status = bcmq_pkg::ST_OK;
		total_d    = total_q;
		nz_set     = 1'b0;
		nz_clr     = 1'b0;
		nz_clr_all = 1'b0;
		case (state_q)
			bcmq_pkg::S_IDLE: begin
				if (accept) begin
					case (bcmq_pkg::mode_t'(mode))
						bcmq_pkg::MODE_PUT: begin
							if (in_range) begin
								ram_re  = 1'b1;
								state_d = bcmq_pkg::S_CALC;
							end else begin
								fin_valid  = 1'b1;
								fin_status = bcmq_pkg::ST_SAT;
							end
						end
						bcmq_pkg::MODE_GET: begin
							state_d = bcmq_pkg::S_SCAN;
						end
						bcmq_pkg::MODE_CLEAR: begin
							nz_clr_all = 1'b1;
							total_d    = '0;
							fin_valid  = 1'b1;
						end
						default: begin
							fin_valid = 1'b1;
						end
					endcase
				end
			end
			bcmq_pkg::S_SCAN: begin
				if (found) begin
					ram_re    = 1'b1;
					ram_raddr = scan_idx;
					state_d   = bcmq_pkg::S_CALC;
				end else if (last_chunk) begin
					fin_valid  = 1'b1;
					fin_status = nz_q[0] ? bcmq_pkg::ST_MARKER : bcmq_pkg::ST_EMPTY;
				end
			end
			bcmq_pkg::S_CALC: begin
				fin_valid = 1'b1;
				if (op_q == bcmq_pkg::MODE_PUT) begin
					if (cnt == '1 || total_q == '1) begin
						fin_status = bcmq_pkg::ST_SAT;
					end else begin
						ram_we  = 1'b1;
						nz_set  = 1'b1;
						total_d = total_q + bcmq_pkg::TOTAL_W'(1);
					end
				end else begin
					ram_we    = 1'b1;
					ram_wdata = cnt - COUNT_BITS'(1);
					nz_clr    = (cnt == COUNT_BITS'(1));
					if (total_q != '0) begin
						total_d = total_q - bcmq_pkg::TOTAL_W'(1);
					end
					fin_taken = bcmq_pkg::VALUE_W'(idx_q);
				end
			end
			bcmq_pkg::S_HOLD: begin
				if (out_free) begin
					state_d = bcmq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bcmq_pkg::S_IDLE;
			end
		endcase
		if (fin_valid) begin
			state_d = out_free ? bcmq_pkg::S_IDLE : bcmq_pkg::S_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bcmq_pkg::S_IDLE;
			nz_q      <= '0;
			total_q   <= '0;
			out_valid <= 1'b0;
			chunk_q   <= '0;
		end else begin
			state_q <= state_d;
			total_q <= total_d;
			if (nz_clr_all) begin
				nz_q <= '0;
			end else if (nz_set) begin
				nz_q[idx_q] <= 1'b1;
			end else if (nz_clr) begin
				nz_q[idx_q] <= 1'b0;
			end
			if (accept) begin
				chunk_q <= '0;
			end else if (state_q == bcmq_pkg::S_SCAN && !found && !last_chunk) begin
				chunk_q <= chunk_q + CI_W'(1);
			end
			if ((fin_valid || state_q == bcmq_pkg::S_HOLD) && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= bcmq_pkg::mode_t'(mode);
			idx_q <= IDX_W'(value);
		end else if (state_q == bcmq_pkg::S_SCAN && found) begin
			idx_q <= scan_idx;
		end
		if (fin_valid) begin
			res_taken_q  <= fin_taken;
			res_status_q <= fin_status;
		end
		if (fin_valid && out_free) begin
			taken_value   <= fin_taken;
			status        <= fin_status;
			pending_total <= total_d;
		end else if (state_q == bcmq_pkg::S_HOLD && out_free) begin
			taken_value   <= res_taken_q;
			status        <= res_status_q;
			pending_total <= total_q;
		end
	end

endmodule

@@ design/bcmq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcmq_checker
// Port-level checks for the bucket count min queue, bound to the top level.
// ----------------------------------------------------------------------------
module bcmq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bcmq_pkg::VALUE_W-1:0]  taken_value,
	input logic [bcmq_pkg::STATUS_W-1:0] status,
	input logic [bcmq_pkg::TOTAL_W-1:0]  pending_total
);

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(taken_value)
			&& $stable(status) && $stable(pending_total))
		else $error("result item changed while stalled");

	// an empty queue has no items counted
	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bcmq_pkg::ST_EMPTY |-> pending_total == '0
			&& taken_value == '0)
		else $error("empty report with nonzero total");

	// the end marker stays queued after it is returned
	a_marker_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bcmq_pkg::ST_MARKER |-> pending_total != '0
			&& taken_value == '0)
		else $error("end marker report inconsistent");

	// saturation never removes a value
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bcmq_pkg::ST_SAT |-> taken_value == '0)
		else $error("saturated put returned a value");

endmodule

bind bucket_count_min_queue_top bcmq_checker u_bcmq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.taken_value  (taken_value),
	.status       (status),
	.pending_total(pending_total)
);
